@@ sv/ppe_pkg.sv @@
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the piecewise polynomial evaluator.
// ----------------------------------------------------------------------------
package ppe_pkg;

	// Command codes carried in the command field
	typedef enum logic [2:0] {
		CMD_COEF   = 3'd0,
		CMD_BOUND  = 3'd1,
		CMD_CENTER = 3'd2,
		CMD_COUNT  = 3'd3,
		CMD_EVAL   = 3'd4
	} ppe_cmd_t;

	localparam int QW = 32;
	localparam int TW = QW + 1;            // width of x - center
	localparam int PW = QW + TW;           // width of acc * t
	localparam int AW = PW + 1;            // width of rounding arithmetic
	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	typedef struct packed {
		logic [2:0]             command;
		logic [4:0]             segment;
		logic [2:0]             term;
		logic signed [QW-1:0]   load_value;
		logic signed [QW-1:0]   point;
	} ppe_req_t;

	typedef struct packed {
		logic signed [QW-1:0]   value;
		logic signed [QW-1:0]   derivative;
		logic                   in_range;
		logic                   saturated;
	} ppe_rsp_t;

	// Control bits that travel with each transaction
	typedef struct packed {
		logic valid;
		logic eval;
		logic hit;
		logic sat;
	} ppe_ctl_t;

endpackage

@@ sv/ppe_chan_if.sv @@
// ----------------------------------------------------------------------------
// ppe_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ppe_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/ppe_horner_step.sv @@
// ----------------------------------------------------------------------------
// ppe_horner_step
// One Horner step for value and derivative: multiply stage, then round,
// add coefficient and saturate stage.
// ----------------------------------------------------------------------------
module ppe_horner_step #(
	parameter int MAX_TERMS = 8,
	parameter int STEP      = 1,
	parameter int TC_W      = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ppe_pkg::ppe_ctl_t             ctl_in,
	input  logic [TC_W-1:0]               n_in,
	input  logic signed [ppe_pkg::TW-1:0] t_in,
	input  logic signed [ppe_pkg::QW-1:0] acc_v_in,
	input  logic signed [ppe_pkg::QW-1:0] acc_d_in,
	input  logic [MAX_TERMS-1:0][ppe_pkg::QW-1:0] c_in,
	input  logic [MAX_TERMS-1:0][ppe_pkg::QW-1:0] d_in,
	output ppe_pkg::ppe_ctl_t             ctl_out,
	output logic [TC_W-1:0]               n_out,
	output logic signed [ppe_pkg::TW-1:0] t_out,
	output logic signed [ppe_pkg::QW-1:0] acc_v_out,
	output logic signed [ppe_pkg::QW-1:0] acc_d_out,
	output logic [MAX_TERMS-1:0][ppe_pkg::QW-1:0] c_out,
	output logic [MAX_TERMS-1:0][ppe_pkg::QW-1:0] d_out
);
	import ppe_pkg::*;

	localparam int SW = $clog2(MAX_TERMS + 2) + 1;

	ppe_ctl_t                       ctl_s1;
	logic [TC_W-1:0]                n_s1;
	logic signed [TW-1:0]           t_s1;
	logic signed [PW-1:0]           pv_s1, pd_s1;
	logic signed [QW-1:0]           av_s1, ad_s1;
	logic [MAX_TERMS-1:0][QW-1:0]   c_s1, d_s1;
	logic                           act_v, act_d;
	logic signed [QW-1:0]           nv, nd;
	logic                           sv, sd;

	// Round half away from zero, add coefficient, saturate to Q16.16
	function automatic logic signed [QW:0] step_f(
		input logic signed [PW-1:0] p,
		input logic signed [QW-1:0] c
	);
		logic signed [AW-1:0] r;
		logic signed [AW-1:0] s;
		logic signed [QW:0]   res;
		r = AW'(p) + (p[PW-1] ? AW'(32767) : AW'(32768));
		s = (r >>> 16) + AW'(c);
		if (s > AW'(Q_MAX))      res = {1'b1, Q_MAX};
		else if (s < AW'(Q_MIN)) res = {1'b1, Q_MIN};
		else                     res = {1'b0, s[QW-1:0]};
		return res;
	endfunction

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= n_in;
			t_s1  <= t_in;
			pv_s1 <= PW'(acc_v_in) * PW'(t_in);
			pd_s1 <= PW'(acc_d_in) * PW'(t_in);
			av_s1 <= acc_v_in;
			ad_s1 <= acc_d_in;
			c_s1  <= c_in;
			d_s1  <= d_in;
		end
	end

	// Value step is active while its index lies below the term count, derivative step while its index plus one does
	assign act_v = SW'(STEP) < SW'(n_s1);
	assign act_d = SW'(STEP + 1) < SW'(n_s1);
	assign {sv, nv} = step_f(pv_s1, c_s1[STEP]);
	assign {sd, nd} = step_f(pd_s1, d_s1[STEP]);

	// Accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= {ctl_s1.valid, ctl_s1.eval, ctl_s1.hit,
			            ctl_s1.sat | (act_v & sv) | (act_d & sd)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_out     <= n_s1;
			t_out     <= t_s1;
			acc_v_out <= act_v ? nv : av_s1;
			acc_d_out <= act_d ? nd : ad_s1;
			c_out     <= c_s1;
			d_out     <= d_s1;
		end
	end

endmodule

@@ sv/piecewise_polynomial_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_polynomial_evaluator_unit
// Piecewise polynomial and derivative evaluator, signed Q16.16.
// ----------------------------------------------------------------------------
// Load commands write bounds, centers, term counts and coefficients; an
// evaluate transaction finds the first active segment holding the point and
// runs Horner's rule on (point - center) for the value and the derivative.
// Each transaction returns one result. The pipeline takes one transaction per
// cycle while the response side is ready; each Horner step has one multiply
// stage and one round/add stage. A load command waits while an evaluate is
// still in the first three stages, where the stores are read.
// ----------------------------------------------------------------------------
module piecewise_polynomial_evaluator_unit #(
	parameter int MAX_SEGMENTS = 16,
	parameter int MAX_TERMS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ppe_chan_if.sink    cfg,
	ppe_chan_if.sink    req,
	ppe_chan_if.source  rsp
);
	import ppe_pkg::*;

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int BI_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int TI_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int TC_W  = $clog2(MAX_TERMS + 1);
	localparam int NS_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int MW    = QW + TC_W + 1;

	ppe_req_t req_d;
	logic     en, eval_busy, acc_req;

	// Stores
	logic signed [QW-1:0]         bound_q [MAX_SEGMENTS+1];
	logic signed [QW-1:0]         center_q [MAX_SEGMENTS];
	logic [TC_W-1:0]              count_q [MAX_SEGMENTS];
	logic [MAX_TERMS-1:0][QW-1:0] coef_mem [MAX_SEGMENTS];
	logic [NS_W-1:0]              ns_q;

	// Pipeline registers
	ppe_ctl_t                     ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [QW-1:0]         x_s1, x_s2, x_s3, x_s4;
	logic [MAX_SEGMENTS:0]        le_s2;
	logic [SEG_W-1:0]             seg_s3;
	logic [MAX_TERMS-1:0][QW-1:0] row_s4;
	logic signed [QW-1:0]         ctr_s4;
	logic [TC_W-1:0]              n_s4;
	logic [TC_W-1:0]              n_s5;
	logic signed [TW-1:0]         t_s5;
	logic signed [QW-1:0]         av_s5, ad_s5;
	logic [MAX_TERMS-1:0][QW-1:0] c_s5, d_s5;
	ppe_rsp_t                     rsp_s6;
	ppe_rsp_t                     rsp_d;

	// Search and derivative lanes
	logic [SEG_W-1:0]             seg_d;
	logic                         hit_d;
	logic [MAX_TERMS-1:0][QW-1:0] dlane;
	logic [MAX_TERMS-1:0]         dsat;

	// Horner chain taps, index 0 is the chain input
	ppe_ctl_t                     ch_ctl [MAX_TERMS];
	logic [TC_W-1:0]              ch_n [MAX_TERMS];
	logic signed [TW-1:0]         ch_t [MAX_TERMS];
	logic signed [QW-1:0]         ch_av [MAX_TERMS];
	logic signed [QW-1:0]         ch_ad [MAX_TERMS];
	logic [MAX_TERMS-1:0][QW-1:0] ch_c [MAX_TERMS];
	logic [MAX_TERMS-1:0][QW-1:0] ch_d [MAX_TERMS];

	assign req_d     = req.payload;
	assign en        = !ctl_s6.valid || rsp.ready;
	assign eval_busy = (ctl_s1.valid && ctl_s1.eval) || (ctl_s2.valid && ctl_s2.eval) ||
	                   (ctl_s3.valid && ctl_s3.eval);
	assign req.ready = en && (req_d.command == CMD_EVAL || !eval_busy);
	assign acc_req   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Hold segment count, clamped to the supported range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q <= NS_W'(1);
		end else if (cfg.valid) begin
			if (cfg.payload == '0)                  ns_q <= NS_W'(1);
			else if (int'(cfg.payload) > MAX_SEGMENTS) ns_q <= NS_W'(MAX_SEGMENTS);
			else                                    ns_q <= NS_W'(cfg.payload);
		end
	end

	// Write term counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SEGMENTS; k++) count_q[k] <= '0;
		end else if (acc_req && req_d.command == CMD_COUNT &&
		             int'(req_d.segment) < MAX_SEGMENTS) begin
			if (req_d.load_value < 0)
				count_q[SEG_W'(req_d.segment)] <= '0;
			else if (req_d.load_value > MAX_TERMS)
				count_q[SEG_W'(req_d.segment)] <= TC_W'(MAX_TERMS);
			else
				count_q[SEG_W'(req_d.segment)] <= TC_W'(req_d.load_value);
		end
	end

	// Write bounds, centers and coefficients
	always_ff @(posedge clk) begin
		if (acc_req) begin
			if (req_d.command == CMD_BOUND && int'(req_d.segment) <= MAX_SEGMENTS)
				bound_q[BI_W'(req_d.segment)] <= req_d.load_value;
			if (req_d.command == CMD_CENTER && int'(req_d.segment) < MAX_SEGMENTS)
				center_q[SEG_W'(req_d.segment)] <= req_d.load_value;
			if (req_d.command == CMD_COEF && int'(req_d.segment) < MAX_SEGMENTS &&
			    int'(req_d.term) < MAX_TERMS)
				coef_mem[SEG_W'(req_d.segment)][TI_W'(req_d.term)] <= req_d.load_value;
		end
	end

	// Advance control through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= {acc_req, req_d.command == CMD_EVAL, 1'b0, 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= {ctl_s2.valid, ctl_s2.eval, hit_d, ctl_s2.sat};
			ctl_s4 <= ctl_s3;
			ctl_s5 <= {ctl_s4.valid, ctl_s4.eval, ctl_s4.hit, |dsat};
		end
	end

	// Find the first active segment that holds x
	always_comb begin
		seg_d = '0;
		hit_d = 1'b0;
		for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
			if (k < int'(ns_q) && le_s2[k] && !le_s2[k+1]) begin
				seg_d = SEG_W'(k);
				hit_d = 1'b1;
			end
		end
	end

	// Scale derivative coefficients by their exponent
	always_comb begin
		logic signed [MW-1:0] m;
		for (int i = 0; i < MAX_TERMS; i++) begin
			m = MW'(signed'(row_s4[i])) * MW'(int'(n_s4) - 1 - i);
			dsat[i] = 1'b0;
			if (m > MW'(Q_MAX)) begin
				dlane[i] = Q_MAX;
				dsat[i]  = (i + 1) < int'(n_s4);
			end else if (m < MW'(Q_MIN)) begin
				dlane[i] = Q_MIN;
				dsat[i]  = (i + 1) < int'(n_s4);
			end else begin
				dlane[i] = m[QW-1:0];
			end
		end
	end

	// Front stage data: compare, select, read stores, form t
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= req_d.point;
			x_s2 <= x_s1;
			for (int k = 0; k <= MAX_SEGMENTS; k++) le_s2[k] <= bound_q[k] <= x_s1;
			x_s3   <= x_s2;
			seg_s3 <= seg_d;
			x_s4   <= x_s3;
			row_s4 <= coef_mem[seg_s3];
			ctr_s4 <= center_q[seg_s3];
			n_s4   <= count_q[seg_s3];
			n_s5   <= n_s4;
			t_s5   <= TW'(x_s4) - TW'(ctr_s4);
			av_s5  <= row_s4[0];
			ad_s5  <= dlane[0];
			c_s5   <= row_s4;
			d_s5   <= dlane;
		end
	end

	assign ch_ctl[0] = ctl_s5;
	assign ch_n[0]   = n_s5;
	assign ch_t[0]   = t_s5;
	assign ch_av[0]  = av_s5;
	assign ch_ad[0]  = ad_s5;
	assign ch_c[0]   = c_s5;
	assign ch_d[0]   = d_s5;

	// Horner chain, one step per remaining term
	for (genvar s = 1; s < MAX_TERMS; s++) begin : g_step
		ppe_horner_step #(
			.MAX_TERMS (MAX_TERMS),
			.STEP      (s),
			.TC_W      (TC_W)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.ctl_in    (ch_ctl[s-1]),
			.n_in      (ch_n[s-1]),
			.t_in      (ch_t[s-1]),
			.acc_v_in  (ch_av[s-1]),
			.acc_d_in  (ch_ad[s-1]),
			.c_in      (ch_c[s-1]),
			.d_in      (ch_d[s-1]),
			.ctl_out   (ch_ctl[s]),
			.n_out     (ch_n[s]),
			.t_out     (ch_t[s]),
			.acc_v_out (ch_av[s]),
			.acc_d_out (ch_ad[s]),
			.c_out     (ch_c[s]),
			.d_out     (ch_d[s])
		);
	end

	// Output register: zero the result fields for loads, misses and short segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s6 <= ch_ctl[MAX_TERMS-1];
		end
	end

	always_comb begin
		rsp_d = '0;
		if (ch_ctl[MAX_TERMS-1].eval && ch_ctl[MAX_TERMS-1].hit) begin
			rsp_d.in_range  = 1'b1;
			rsp_d.saturated = ch_ctl[MAX_TERMS-1].sat;
			if (ch_n[MAX_TERMS-1] != '0)
				rsp_d.value = ch_av[MAX_TERMS-1];
			if (int'(ch_n[MAX_TERMS-1]) >= 2)
				rsp_d.derivative = ch_ad[MAX_TERMS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s6 <= rsp_d;
		end
	end

	assign rsp.valid   = ctl_s6.valid;
	assign rsp.payload = rsp_s6;

endmodule
